FILE: rtl/websocket_frame_deframer_assert.svh
// ---------------------------------------------------------------------------
// websocket frame deframer assertion macros
// shared property wrappers, clocked and held off during reset
// ---------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH

// same-cycle implication
`define WSDF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("deframer assertion failed");

// next-cycle implication
`define WSDF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("deframer assertion failed");

`endif

FILE: rtl/wsdf_pkg.sv
// ---------------------------------------------------------------------------
// wsdf_pkg
// types and constants shared by the websocket frame deframer
// ---------------------------------------------------------------------------
package wsdf_pkg;

	localparam int BYTE_W   = 8;
	localparam int OPCODE_W = 4;
	localparam int LENGTH_W = 64;
	localparam int KIND_W   = 2;
	localparam int MAXP_W   = 32;
	localparam int KEY_W    = 32;
	localparam int HDR_W    = 4;

	localparam logic [31:0] MAXP_RESET = 32'd4096;

	// short length codes that select an extended length
	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	localparam logic [HDR_W-1:0] EXT16_BYTES = 4'd2;
	localparam logic [HDR_W-1:0] EXT64_BYTES = 4'd8;
	localparam logic [HDR_W-1:0] MASK_BYTES  = 4'd4;

	localparam logic [KIND_W-1:0] KIND_DATA  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DROP  = 2'd2;

	typedef enum logic [2:0] {
		PH_FIRST,
		PH_SECOND,
		PH_EXTLEN,
		PH_MASK,
		PH_PAYLOAD
	} phase_t;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [BYTE_W-1:0]   data;
		logic [OPCODE_W-1:0] opcode;
		logic [LENGTH_W-1:0] length;
		logic                last;
	} result_t;

endpackage

FILE: rtl/wsdf_if.sv
// ---------------------------------------------------------------------------
// wsdf channel interfaces
// valid/ready channels for the received byte stream and the parsed results
// ---------------------------------------------------------------------------
interface wsdf_in_if;
	logic                       valid;
	logic                       ready;
	logic [wsdf_pkg::BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface wsdf_out_if;
	logic                         valid;
	logic                         ready;
	logic [wsdf_pkg::KIND_W-1:0]   out_kind;
	logic [wsdf_pkg::BYTE_W-1:0]   out_byte;
	logic [wsdf_pkg::OPCODE_W-1:0] out_opcode;
	logic [wsdf_pkg::LENGTH_W-1:0] out_length;
	logic                         out_last;

	modport source (
		output valid, output out_kind, output out_byte, output out_opcode,
		output out_length, output out_last, input ready
	);
	modport sink (
		input valid, input out_kind, input out_byte, input out_opcode,
		input out_length, input out_last, output ready
	);
endinterface

FILE: rtl/websocket_frame_deframer.sv
// ---------------------------------------------------------------------------
// websocket_frame_deframer
// Parses a received WebSocket byte stream, one byte per transfer, and emits
// one result per payload byte (unmasked with the frame's key), one result
// for an empty frame on its last header byte, and one drop result on the
// final byte of a frame longer than max_payload. Header bytes other than a
// completing empty header give no result. A byte is taken every cycle while
// results are taken; each byte passes through the input register and then
// the result register. The cycle time is set by the 64-bit payload counter
// increment and compare and the extended length compare against max_payload.
// max_payload resets to 4096 and is written with cfg_we; the user must write
// it only while no frame is in flight, which the block itself does not enforce.
// ---------------------------------------------------------------------------
module websocket_frame_deframer (
	input  logic                        clk,
	input  logic                        arst_n,
	wsdf_in_if.sink                     rx,
	wsdf_out_if.source                  res,
	input  logic                        cfg_we,
	input  logic [wsdf_pkg::MAXP_W-1:0] cfg_wdata
);

	logic              adv;
	logic              res_valid;
	wsdf_pkg::result_t res_data;

	wsdf_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.adv       (adv),
		.res_valid (res_valid),
		.res_data  (res_data)
	);

	wsdf_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_data  (res_data),
		.adv       (adv),
		.res       (res)
	);

endmodule

FILE: rtl/wsdf_parser.sv
// ---------------------------------------------------------------------------
// wsdf_parser
// input register and frame header / payload parser with the size limit
// ---------------------------------------------------------------------------
`include "websocket_frame_deframer_assert.svh"

module wsdf_parser (
	input  logic                           clk,
	input  logic                           arst_n,
	wsdf_in_if.sink                        rx,
	input  logic                           cfg_we,
	input  logic [wsdf_pkg::MAXP_W-1:0]    cfg_wdata,
	input  logic                           adv,
	output logic                           res_valid,
	output wsdf_pkg::result_t              res_data
);

	logic                           valid_s1;
	logic [wsdf_pkg::BYTE_W-1:0]    byte_s1;
	logic                           take;

	logic [wsdf_pkg::MAXP_W-1:0]    max_q;
	wsdf_pkg::phase_t               phase_q, phase_d;
	logic [wsdf_pkg::OPCODE_W-1:0]  opcode_q, opcode_d;
	logic                           mask_q, mask_d;
	logic [wsdf_pkg::LENGTH_W-1:0]  len_q, len_d;
	logic [wsdf_pkg::HDR_W-1:0]     hdr_q, hdr_d;
	logic                           ext8_q, ext8_d;
	logic [wsdf_pkg::KEY_W-1:0]     key_q, key_d;
	logic [wsdf_pkg::LENGTH_W-1:0]  cnt_q, cnt_d;
	logic                           drop_q, drop_d;

	logic [6:0]                     len7;
	logic                           len7_ext;
	logic [wsdf_pkg::LENGTH_W-1:0]  len_n;
	logic                           len_empty;
	logic [wsdf_pkg::HDR_W-1:0]     hdr_inc;
	logic [wsdf_pkg::HDR_W-1:0]     ext_target;
	logic [wsdf_pkg::LENGTH_W-1:0]  cnt_inc;
	logic                           pay_last;
	logic [1:0]                     key_idx;
	logic [wsdf_pkg::BYTE_W-1:0]    key_byte;
	logic                           hdr_fin;
	logic                           emit;

	// input register, refilled when empty or whenever the parser moves its byte on
	assign take     = valid_s1 && adv;
	assign rx.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= wsdf_pkg::MAXP_RESET;
		end else if (cfg_we) begin
			max_q <= cfg_wdata;
		end
	end

	// shared datapath terms
	assign len7     = byte_s1[6:0];
	assign len7_ext = (len7 == wsdf_pkg::LEN_EXT16) || (len7 == wsdf_pkg::LEN_EXT64);
	assign hdr_inc  = hdr_q + 4'd1;
	assign ext_target = ext8_q ? wsdf_pkg::EXT64_BYTES : wsdf_pkg::EXT16_BYTES;
	assign cnt_inc  = cnt_q + 64'd1;
	assign pay_last = cnt_inc >= len_q;
	assign key_idx  = cnt_q[1:0];
	assign key_byte = mask_q ? key_q[{~key_idx, 3'b000} +: 8] : 8'd0;

	always_comb begin
		case (phase_q)
			wsdf_pkg::PH_SECOND: len_n = len7_ext ? 64'd0 : {57'd0, len7};
			wsdf_pkg::PH_EXTLEN: len_n = {len_q[55:0], byte_s1};
			default:             len_n = len_q;
		endcase
	end

	assign len_empty = (len_n == 64'd0);

	// next state
	always_comb begin
		phase_d  = phase_q;
		opcode_d = opcode_q;
		mask_d   = mask_q;
		len_d    = len_q;
		hdr_d    = hdr_q;
		ext8_d   = ext8_q;
		key_d    = key_q;
		cnt_d    = cnt_q;
		drop_d   = drop_q;
		hdr_fin  = 1'b0;
		unique case (phase_q)
			wsdf_pkg::PH_FIRST: begin
				opcode_d = byte_s1[3:0];
				mask_d   = 1'b0;
				len_d    = 64'd0;
				key_d    = 32'd0;
				cnt_d    = 64'd0;
				drop_d   = 1'b0;
				hdr_d    = 4'd0;
				phase_d  = wsdf_pkg::PH_SECOND;
			end
			wsdf_pkg::PH_SECOND: begin
				mask_d = byte_s1[7];
				hdr_d  = 4'd0;
				len_d  = len_n;
				if (len7_ext) begin
					ext8_d  = (len7 == wsdf_pkg::LEN_EXT64);
					phase_d = wsdf_pkg::PH_EXTLEN;
				end else if (byte_s1[7]) begin
					phase_d = wsdf_pkg::PH_MASK;
				end else begin
					hdr_fin = 1'b1;
				end
			end
			wsdf_pkg::PH_EXTLEN: begin
				len_d = len_n;
				hdr_d = hdr_inc;
				if (hdr_inc >= ext_target) begin
					hdr_d = 4'd0;
					if (mask_q) begin
						phase_d = wsdf_pkg::PH_MASK;
					end else begin
						hdr_fin = 1'b1;
					end
				end
			end
			wsdf_pkg::PH_MASK: begin
				key_d = {key_q[23:0], byte_s1};
				hdr_d = hdr_inc;
				if (hdr_inc >= wsdf_pkg::MASK_BYTES) begin
					hdr_fin = 1'b1;
				end
			end
			wsdf_pkg::PH_PAYLOAD: begin
				cnt_d = cnt_inc;
				if (pay_last) begin
					phase_d = wsdf_pkg::PH_FIRST;
					drop_d  = 1'b0;
				end
			end
			default: begin
				phase_d = wsdf_pkg::PH_FIRST;
			end
		endcase
		// header complete: empty frames end here, others enter the payload
		if (hdr_fin) begin
			cnt_d = 64'd0;
			hdr_d = 4'd0;
			if (len_empty) begin
				drop_d  = 1'b0;
				phase_d = wsdf_pkg::PH_FIRST;
			end else begin
				drop_d  = len_n > {32'd0, max_q};
				phase_d = wsdf_pkg::PH_PAYLOAD;
			end
		end
	end

	// result for the byte in the input register
	always_comb begin
		emit            = 1'b0;
		res_data.kind   = wsdf_pkg::KIND_DATA;
		res_data.data   = 8'd0;
		res_data.opcode = opcode_q;
		res_data.length = len_n;
		res_data.last   = 1'b1;
		unique case (phase_q)
			wsdf_pkg::PH_SECOND: begin
				if (!len7_ext && !byte_s1[7] && len_empty) begin
					emit          = 1'b1;
					res_data.kind = wsdf_pkg::KIND_EMPTY;
				end
			end
			wsdf_pkg::PH_EXTLEN: begin
				if (hdr_inc >= ext_target && !mask_q && len_empty) begin
					emit          = 1'b1;
					res_data.kind = wsdf_pkg::KIND_EMPTY;
				end
			end
			wsdf_pkg::PH_MASK: begin
				if (hdr_inc >= wsdf_pkg::MASK_BYTES && len_empty) begin
					emit          = 1'b1;
					res_data.kind = wsdf_pkg::KIND_EMPTY;
				end
			end
			wsdf_pkg::PH_PAYLOAD: begin
				if (!drop_q) begin
					emit          = 1'b1;
					res_data.data = byte_s1 ^ key_byte;
					res_data.last = pay_last;
				end else if (pay_last) begin
					emit          = 1'b1;
					res_data.kind = wsdf_pkg::KIND_DROP;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	assign res_valid = take && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= wsdf_pkg::PH_FIRST;
			opcode_q <= '0;
			mask_q   <= 1'b0;
			len_q    <= '0;
			hdr_q    <= '0;
			ext8_q   <= 1'b0;
			key_q    <= '0;
			cnt_q    <= '0;
			drop_q   <= 1'b0;
		end else if (take) begin
			phase_q  <= phase_d;
			opcode_q <= opcode_d;
			mask_q   <= mask_d;
			len_q    <= len_d;
			hdr_q    <= hdr_d;
			ext8_q   <= ext8_d;
			key_q    <= key_d;
			cnt_q    <= cnt_d;
			drop_q   <= drop_d;
		end
	end

	`WSDF_ASSERT_IMP(a_payload_nonempty, clk, arst_n,
		phase_q == wsdf_pkg::PH_PAYLOAD, len_q != 64'd0)
	`WSDF_ASSERT_IMP(a_drop_in_payload, clk, arst_n,
		drop_q, phase_q == wsdf_pkg::PH_PAYLOAD)
	`WSDF_ASSERT_NXT(a_end_returns_first, clk, arst_n,
		res_valid && res_data.last, phase_q == wsdf_pkg::PH_FIRST)
	`WSDF_ASSERT_IMP(a_non_data_is_last, clk, arst_n,
		res_valid && res_data.kind != wsdf_pkg::KIND_DATA,
		res_data.last && res_data.data == 8'd0)

endmodule

FILE: rtl/wsdf_out_reg.sv
// ---------------------------------------------------------------------------
// wsdf_out_reg
// result register that holds one parsed result until it is taken
// ---------------------------------------------------------------------------
module wsdf_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_valid,
	input  wsdf_pkg::result_t res_data,
	output logic              adv,
	wsdf_out_if.source        res
);

	logic              valid_q;
	wsdf_pkg::result_t data_q;

	// register is free when empty or when its transfer completes now
	assign adv = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			data_q <= res_data;
		end
	end

	assign res.valid      = valid_q;
	assign res.out_kind   = data_q.kind;
	assign res.out_byte   = data_q.data;
	assign res.out_opcode = data_q.opcode;
	assign res.out_length = data_q.length;
	assign res.out_last   = data_q.last;

endmodule

FILE: test/tb_websocket_frame_deframer.sv
// ---------------------------------------------------------------------------
// tb_websocket_frame_deframer
// Sends WebSocket frames byte by byte with random gaps and result stalls,
// predicts every payload, empty and drop result from the accepted bytes and
// checks each result field by field. The max_payload limit is changed between
// frame groups, including both extremes.
// ---------------------------------------------------------------------------
module tb_websocket_frame_deframer;

	localparam int unsigned IDLE_LIMIT = 400;

	typedef enum int {ENC_SHORT, ENC_EXT16, ENC_EXT64} len_enc_t;

	class frame_scoreboard;
		wsdf_pkg::phase_t                      phase;
		logic [wsdf_pkg::OPCODE_W-1:0]         opcode;
		logic                                  masked;
		logic [wsdf_pkg::LENGTH_W-1:0]         length;
		logic [wsdf_pkg::HDR_W-1:0]            hdr_cnt;
		logic [wsdf_pkg::HDR_W-1:0]            ext_bytes;
		logic [wsdf_pkg::KEY_W-1:0]            key;
		logic [wsdf_pkg::LENGTH_W-1:0]         count;
		logic                                  dropping;
		logic [wsdf_pkg::MAXP_W-1:0]           max_len;
		wsdf_pkg::result_t                     expected_q[$];
		int unsigned                           fails;

		function new();
			phase     = wsdf_pkg::PH_FIRST;
			opcode    = '0;
			masked    = 1'b0;
			length    = '0;
			hdr_cnt   = '0;
			ext_bytes = '0;
			key       = '0;
			count     = '0;
			dropping  = 1'b0;
			max_len   = wsdf_pkg::MAXP_RESET;
			fails     = 0;
		endfunction

		function void set_limit(logic [wsdf_pkg::MAXP_W-1:0] value);
			max_len = value;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void add_expect(logic [wsdf_pkg::KIND_W-1:0] kind,
				logic [wsdf_pkg::BYTE_W-1:0] data, logic last);
			wsdf_pkg::result_t r;
			r.kind   = kind;
			r.data   = data;
			r.opcode = opcode;
			r.length = length;
			r.last   = last;
			expected_q.push_back(r);
		endfunction

		function void header_complete();
			count   = '0;
			hdr_cnt = '0;
			if (length == 0) begin
				dropping = 1'b0;
				phase    = wsdf_pkg::PH_FIRST;
				add_expect(wsdf_pkg::KIND_EMPTY, '0, 1'b1);
			end else begin
				dropping = length > {32'd0, max_len};
				phase    = wsdf_pkg::PH_PAYLOAD;
			end
		endfunction

		function void note_byte(logic [wsdf_pkg::BYTE_W-1:0] b);
			logic [1:0]                  idx;
			logic [wsdf_pkg::BYTE_W-1:0] key_byte;
			logic                        last;
			case (phase)
				wsdf_pkg::PH_FIRST: begin
					opcode   = b[3:0];
					masked   = 1'b0;
					length   = '0;
					key      = '0;
					count    = '0;
					dropping = 1'b0;
					hdr_cnt  = '0;
					phase    = wsdf_pkg::PH_SECOND;
				end
				wsdf_pkg::PH_SECOND: begin
					masked  = b[7];
					hdr_cnt = '0;
					if (b[6:0] == wsdf_pkg::LEN_EXT16 || b[6:0] == wsdf_pkg::LEN_EXT64) begin
						ext_bytes = (b[6:0] == wsdf_pkg::LEN_EXT16) ?
							wsdf_pkg::EXT16_BYTES : wsdf_pkg::EXT64_BYTES;
						length    = '0;
						phase     = wsdf_pkg::PH_EXTLEN;
					end else begin
						length = {57'd0, b[6:0]};
						if (masked)
							phase = wsdf_pkg::PH_MASK;
						else
							header_complete();
					end
				end
				wsdf_pkg::PH_EXTLEN: begin
					length  = {length[wsdf_pkg::LENGTH_W-9:0], b};
					hdr_cnt = hdr_cnt + 1'b1;
					if (hdr_cnt >= ext_bytes) begin
						hdr_cnt = '0;
						if (masked)
							phase = wsdf_pkg::PH_MASK;
						else
							header_complete();
					end
				end
				wsdf_pkg::PH_MASK: begin
					key     = {key[wsdf_pkg::KEY_W-9:0], b};
					hdr_cnt = hdr_cnt + 1'b1;
					if (hdr_cnt >= wsdf_pkg::MASK_BYTES)
						header_complete();
				end
				wsdf_pkg::PH_PAYLOAD: begin
					// first key byte received applies to payload index 0
					idx      = count[1:0];
					key_byte = masked ? key[31 - 8 * idx -: 8] : '0;
					count    = count + 1'b1;
					last     = count >= length;
					if (last)
						phase = wsdf_pkg::PH_FIRST;
					if (dropping) begin
						if (last) begin
							dropping = 1'b0;
							add_expect(wsdf_pkg::KIND_DROP, '0, 1'b1);
						end
					end else begin
						add_expect(wsdf_pkg::KIND_DATA, b ^ key_byte, last);
					end
				end
				default: phase = wsdf_pkg::PH_FIRST;
			endcase
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				fails++;
			end
		endfunction

		function void check_result(wsdf_pkg::result_t got);
			wsdf_pkg::result_t want;
			if (expected_q.size() == 0) begin
				$error("result with no expected transfer: kind %0d byte %0h", got.kind,
					got.data);
				fails++;
				return;
			end
			want = expected_q.pop_front();
			compare_field("out_kind", want.kind, got.kind);
			compare_field("out_byte", want.data, got.data);
			compare_field("out_opcode", want.opcode, got.opcode);
			compare_field("out_length", want.length, got.length);
			compare_field("out_last", want.last, got.last);
		endfunction
	endclass

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        cfg_we;
	logic [wsdf_pkg::MAXP_W-1:0] cfg_wdata;

	wsdf_in_if  rx();
	wsdf_out_if res();

	frame_scoreboard sb;
	int unsigned     bytes_sent;
	int unsigned     idle_cycles;
	bit              src_quiet;
	bit              sink_quiet;

	websocket_frame_deframer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.res      (res),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// transfer monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (rx.valid && rx.ready)
				sb.note_byte(rx.rx_byte);
			if (res.valid && res.ready)
				sb.check_result({res.out_kind, res.out_byte, res.out_opcode, res.out_length,
					res.out_last});
			if ((rx.valid && rx.ready) || (res.valid && res.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_websocket_frame_deframer: done, errors");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// result side: random stall before each transfer, with quiet stretches
	initial begin
		int unsigned stall;
		res.ready <= 1'b0;
		sink_quiet = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 63) == 0)
				sink_quiet = !sink_quiet;
			stall = sink_quiet ? 0 : $urandom_range(0, 13);
			if (stall != 0) begin
				res.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res.ready <= 1'b1;
			@(posedge clk);
			while (!res.valid)
				@(posedge clk);
		end
	end

	task automatic push_byte(input logic [wsdf_pkg::BYTE_W-1:0] b);
		int unsigned gap;
		gap = src_quiet ? 0 : $urandom_range(0, 13);
		if (gap != 0) begin
			rx.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx.valid   <= 1'b1;
		rx.rx_byte <= b;
		@(posedge clk);
		while (!rx.ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_frame(input logic [7:0] hdr0, input logic masked, input len_enc_t enc,
			input logic [wsdf_pkg::LENGTH_W-1:0] len, input logic [wsdf_pkg::KEY_W-1:0] key,
			input int unsigned n_body);
		logic [6:0] code;
		code = (enc == ENC_SHORT) ? len[6:0] :
			((enc == ENC_EXT16) ? wsdf_pkg::LEN_EXT16 : wsdf_pkg::LEN_EXT64);
		push_byte(hdr0);
		push_byte({masked, code});
		if (enc == ENC_EXT16) begin
			for (int i = 1; i >= 0; i--)
				push_byte(len[8 * i +: 8]);
		end else if (enc == ENC_EXT64) begin
			for (int i = 7; i >= 0; i--)
				push_byte(len[8 * i +: 8]);
		end
		if (masked) begin
			for (int i = 3; i >= 0; i--)
				push_byte(key[8 * i +: 8]);
		end
		repeat (n_body)
			push_byte(8'($urandom_range(0, 255)));
	endtask

	// mostly small frames, some extended lengths, a few long ones
	task automatic run_frames(input int unsigned budget);
		int unsigned                   stop_at;
		int unsigned                   pick;
		logic [wsdf_pkg::LENGTH_W-1:0] len;
		len_enc_t                      enc;
		stop_at = bytes_sent + budget;
		while (bytes_sent < stop_at) begin
			src_quiet = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 15);
			if (pick < 2)
				len = '0;
			else if (pick < 13)
				len = {32'd0, $urandom_range(1, 20)};
			else
				len = {32'd0, $urandom_range(21, 300)};
			pick = $urandom_range(0, 15);
			if (len > 125 || pick >= 12)
				enc = pick[0] ? ENC_EXT64 : ENC_EXT16;
			else
				enc = ENC_SHORT;
			send_frame(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), enc, len,
				$urandom, len[31:0]);
		end
	endtask

	task automatic wait_drained();
		rx.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		// header bytes give no result, so allow the pipeline to empty
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(input logic [wsdf_pkg::MAXP_W-1:0] value);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_limit(value);
	endtask

	initial begin
		sb          = new();
		bytes_sent  = 0;
		idle_cycles = 0;
		src_quiet   = 1'b0;
		arst_n     <= 1'b0;
		cfg_we     <= 1'b0;
		cfg_wdata  <= '0;
		rx.valid   <= 1'b0;
		rx.rx_byte <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty short frames, masked and unmasked, a non-minimal extended length, mask wrap
		send_frame(8'h8F, 1'b0, ENC_SHORT, 64'd0, '0, 0);
		send_frame(8'h70, 1'b1, ENC_SHORT, 64'd0, 32'hFF00_A55A, 0);
		send_frame(8'h01, 1'b0, ENC_EXT16, 64'd1, '0, 1);
		send_frame(8'h82, 1'b1, ENC_SHORT, 64'd5, 32'h0F1E_2D3C, 5);

		write_limit(32'd5);
		run_frames(200);
		write_limit(32'd0);
		run_frames(150);
		write_limit(32'hFFFF_FFFF);
		run_frames(350);
		write_limit($urandom_range(6, 60));
		run_frames(350);
		write_limit(wsdf_pkg::MAXP_RESET);
		run_frames(350);

		src_quiet = 1'b1;

		// 64-bit length with the top bit set never completes, so nothing comes out
		send_frame(8'h89, 1'b0, ENC_EXT64, 64'h8000_0000_0000_0003, '0, 12);

		wait_drained();
		repeat (4) @(posedge clk);
		if (sb.fails == 0)
			$display("tb_websocket_frame_deframer: done, clean");
		else
			$display("tb_websocket_frame_deframer: done, errors");
		$finish;
	end

endmodule
